// File: design/hex_text_to_bytes_macros.svh
// ---------------------------------------------------------------------------
// hex_text_to_bytes_macros
// assertion macros used by the hex text decoder
// ---------------------------------------------------------------------------
`ifndef HEX_TEXT_TO_BYTES_MACROS_SVH
`define HEX_TEXT_TO_BYTES_MACROS_SVH

// same-cycle implication, checked outside reset
`define HTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/htb_pkg.sv
// ---------------------------------------------------------------------------
// htb_pkg
// types and constants of the hex text decoder
// ---------------------------------------------------------------------------
package htb_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int OUT_DATA_BITS = 48;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_BYTES     = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IGNORE_COUNT  = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IGNORE_CHAR_A = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_IGNORE_CHAR_B = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_STOP_ALLOWED  = 3'd4;

  // character codes used by the classifier
  localparam logic [7:0] CHAR_ZERO   = 8'd48;
  localparam logic [7:0] CHAR_ALPHA  = 8'd55;   // 'A' minus ten
  localparam logic [7:0] CASE_MASK   = 8'hDF;
  localparam logic [7:0] CHAR_NUL    = 8'd0;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ROOM      = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] max_bytes;
    logic [1:0]  ignore_count;
    logic [7:0]  ignore_char_a;
    logic [7:0]  ignore_char_b;
    logic        stop_allowed;
  } cfg_t;

  typedef struct packed {
    logic       is_hex;
    logic       is_sep;
    logic [3:0] value;
  } char_class_t;

endpackage

// File: design/hex_text_to_bytes.sv
// ---------------------------------------------------------------------------
// hex_text_to_bytes
// streaming hex text to byte decoder with end-of-text report
// ---------------------------------------------------------------------------
// One character word is taken per clock cycle and its result, if any, is
// presented in the next cycle from the output register; the input stays ready
// while that register is empty or being drained, so throughput is one word
// per cycle, set by the combinational state update of the pair register and
// the byte and character counters. A byte comes out as tuser high when its
// second digit arrives; the word flagged tlast yields a report on tlast with
// status, byte count (zero on error) and end position in the same word.
// Configuration writes are always ready and take effect at once.
`include "hex_text_to_bytes_macros.svh"

module hex_text_to_bytes
  import htb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // input words
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] text_char
  input  logic                     s_axis_tuser,   // [0] no_char
  input  logic                     s_axis_tlast,   // is_last
  // result words
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                                   // [25:10] byte_count,
                                                   // [41:26] end_position, rest 0
  output logic                     m_axis_tuser,   // [0] byte_valid
  output logic                     m_axis_tlast,   // done_res
  // configuration writes
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg;

  logic                  second_digit, second_digit_next;
  logic [3:0]            high_digit, high_digit_next;
  logic [15:0]           bytes_out, bytes_out_next;
  logic [COUNT_BITS-1:0] chars_used, chars_used_next;
  logic                  halted, halted_next;
  logic                  room_error, room_error_next;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_done;
  status_t     out_status;
  logic [15:0] out_count;
  logic [15:0] out_pos;

  char_class_t cls;
  logic        in_acc;
  logic        bump;
  logic        res_byte_valid;
  logic [7:0]  res_byte;
  logic        emit;
  status_t     res_status;
  logic [32:0] pos_full;
  logic [15:0] res_pos;

  htb_classify u_classify (
    .text_char (s_axis_tdata),
    .cfg       (cfg),
    .cls       (cls)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_bytes     <= 16'hFFFF;
      cfg.ignore_count  <= 2'd0;
      cfg.ignore_char_a <= 8'd58;
      cfg.ignore_char_b <= 8'd32;
      cfg.stop_allowed  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        CFG_MAX_BYTES:     cfg.max_bytes     <= cfg_data;
        CFG_IGNORE_COUNT:  cfg.ignore_count  <= cfg_data[1:0];
        CFG_IGNORE_CHAR_A: cfg.ignore_char_a <= cfg_data[7:0];
        CFG_IGNORE_CHAR_B: cfg.ignore_char_b <= cfg_data[7:0];
        CFG_STOP_ALLOWED:  cfg.stop_allowed  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-word decode step
  always_comb begin
    second_digit_next = second_digit;
    high_digit_next   = high_digit;
    bytes_out_next    = bytes_out;
    halted_next       = halted;
    room_error_next   = room_error;
    bump              = 1'b0;
    res_byte_valid    = 1'b0;
    res_byte          = 8'd0;
    if (!s_axis_tuser && !halted) begin
      if (!cls.is_hex) begin
        if (!second_digit && cls.is_sep) begin
          bump = 1'b1;
        end else begin
          halted_next = 1'b1;
        end
      end else if (bytes_out >= cfg.max_bytes) begin
        room_error_next = 1'b1;
        halted_next     = 1'b1;
      end else if (!second_digit) begin
        high_digit_next   = cls.value;
        second_digit_next = 1'b1;
        bump              = 1'b1;
      end else begin
        res_byte_valid    = 1'b1;
        res_byte          = {high_digit, cls.value};
        bytes_out_next    = bytes_out + 16'd1;
        second_digit_next = 1'b0;
        bump              = 1'b1;
      end
    end
    chars_used_next = (bump && chars_used != {COUNT_BITS{1'b1}}) ?
                      chars_used + COUNT_BITS'(1) : chars_used;
  end

  // end-of-text report from the updated state
  always_comb begin
    // a dangling high digit is not counted as consumed
    pos_full = 33'(chars_used_next) - 33'(second_digit_next);
    res_pos  = (pos_full > 33'h0FFFF) ? 16'hFFFF : pos_full[15:0];
    if (room_error_next) begin
      res_status = ST_ROOM;
    end else if (second_digit_next || (halted_next && !cfg.stop_allowed)) begin
      res_status = ST_MALFORMED;
    end else begin
      res_status = ST_OK;
    end
  end

  assign emit = s_axis_tlast || res_byte_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_digit <= 1'b0;
      high_digit   <= 4'd0;
      bytes_out    <= 16'd0;
      chars_used   <= '0;
      halted       <= 1'b0;
      room_error   <= 1'b0;
    end else if (in_acc) begin
      if (s_axis_tlast) begin
        second_digit <= 1'b0;
        high_digit   <= 4'd0;
        bytes_out    <= 16'd0;
        chars_used   <= '0;
        halted       <= 1'b0;
        room_error   <= 1'b0;
      end else begin
        second_digit <= second_digit_next;
        high_digit   <= high_digit_next;
        bytes_out    <= bytes_out_next;
        chars_used   <= chars_used_next;
        halted       <= halted_next;
        room_error   <= room_error_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= emit;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_byte       <= res_byte;
      out_byte_valid <= res_byte_valid;
      out_done       <= s_axis_tlast;
      out_status     <= s_axis_tlast ? res_status : ST_OK;
      out_count      <= (s_axis_tlast && res_status == ST_OK) ? bytes_out_next : 16'd0;
      out_pos        <= s_axis_tlast ? res_pos : 16'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_pos, out_count, out_status, out_byte};
  assign m_axis_tuser  = out_byte_valid;
  assign m_axis_tlast  = out_done;

  `HTB_ASSERT_NOW(a_no_overwrite, out_valid && !m_axis_tready, !in_acc,
    "held result word overwritten")
  `HTB_ASSERT_NOW(a_err_count_zero, out_valid && out_done && out_status != ST_OK,
    out_count == 16'd0, "error report carries a byte count")
  `HTB_ASSERT_NEXT(a_text_cleared, in_acc && s_axis_tlast,
    bytes_out == 16'd0 && !second_digit && !halted && !room_error,
    "text state not cleared after last word")
  `HTB_ASSERT_NEXT(a_byte_counted, in_acc && res_byte_valid && !s_axis_tlast,
    bytes_out == $past(bytes_out) + 16'd1, "decoded byte not counted")

endmodule

// File: design/htb_classify.sv
// ---------------------------------------------------------------------------
// htb_classify
// sorts one character into hex digit, separator or other
// ---------------------------------------------------------------------------
module htb_classify
  import htb_pkg::*;
(
  input  logic [7:0]  text_char,
  input  cfg_t        cfg,
  output char_class_t cls
);

  logic [7:0] upper;
  logic [7:0] dec_off;
  logic [7:0] alpha_off;

  assign upper     = text_char & CASE_MASK;
  assign dec_off   = text_char - CHAR_ZERO;
  assign alpha_off = upper - CHAR_ALPHA;

  always_comb begin
    cls = '0;
    if (text_char >= CHAR_ZERO && text_char < CHAR_ZERO + 8'd10) begin
      cls.is_hex = 1'b1;
      cls.value  = dec_off[3:0];
    end else if (upper >= CHAR_ALPHA + 8'd10 && upper < CHAR_ALPHA + 8'd16) begin
      cls.is_hex = 1'b1;
      cls.value  = alpha_off[3:0];
    end
    // a count of three behaves as two
    if (cfg.ignore_count != 2'd0) begin
      cls.is_sep = (text_char == CHAR_NUL) || (text_char == cfg.ignore_char_a) ||
                   (cfg.ignore_count[1] && text_char == cfg.ignore_char_b);
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the hex text decoder: character words go in over
// the input stream, a scoreboard works out each byte and end-of-text report
// and checks every result word in order; the receiver idles at random, and so
// does the sender outside steady sends
module testbench;
  import htb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          RANDOM_ITEMS  = 900;
  localparam int          PHASE_ITEMS   = 100;
  localparam int          PRESSURE_PHASE = 2;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        done;
    status_t     status;
    logic [15:0] byte_count;
    logic [15:0] end_pos;
  } result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       no_char;
  } text_word_t;

  typedef enum int {TXT_CLEAN, TXT_ODD, TXT_BROKEN, TXT_NOISE} text_kind_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  class byte_scoreboard;
    cfg_t        regs;
    logic        second_digit;
    logic [3:0]  high_nib;
    logic [15:0] bytes_out;
    logic [15:0] chars_used;
    logic        halted;
    logic        room_err;
    result_t     due_words[$];
    int unsigned errors;

    function new();
      regs = '{max_bytes: 16'hFFFF, ignore_count: 2'd0, ignore_char_a: ":",
               ignore_char_b: " ", stop_allowed: 1'b0};
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      second_digit = 1'b0;
      high_nib = '0;
      bytes_out = '0;
      chars_used = '0;
      halted = 1'b0;
      room_err = 1'b0;
    endfunction

    function void set_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
      case (addr)
        CFG_MAX_BYTES:     regs.max_bytes = data;
        CFG_IGNORE_COUNT:  regs.ignore_count = data[1:0];
        CFG_IGNORE_CHAR_A: regs.ignore_char_a = data[7:0];
        CFG_IGNORE_CHAR_B: regs.ignore_char_b = data[7:0];
        CFG_STOP_ALLOWED:  regs.stop_allowed = data[0];
        default: ;
      endcase
    endfunction

    // decodes one accepted character word and queues the result it causes
    function void note_word(logic [7:0] ch, logic no_char, logic last);
      result_t    r;
      logic [7:0] up;
      logic [3:0] nib;
      logic       is_hex;
      logic       is_sep;
      logic       consumed;
      r = '0;
      is_hex = 1'b0;
      nib = '0;
      consumed = 1'b0;
      if (ch >= CHAR_ZERO && ch < CHAR_ZERO + 10) begin
        is_hex = 1'b1;
        nib = 4'(ch - CHAR_ZERO);
      end
      up = ch & CASE_MASK;
      if (up >= CHAR_ALPHA + 10 && up < CHAR_ALPHA + 16) begin
        is_hex = 1'b1;
        nib = 4'(up - CHAR_ALPHA);
      end
      // a count of three behaves as two
      is_sep = (regs.ignore_count != 0) &&
               (ch == CHAR_NUL || ch == regs.ignore_char_a ||
                (regs.ignore_count >= 2 && ch == regs.ignore_char_b));
      if (!no_char && !halted) begin
        if (!is_hex) begin
          if (!second_digit && is_sep) consumed = 1'b1;
          else halted = 1'b1;
        end else if (bytes_out >= regs.max_bytes) begin
          room_err = 1'b1;
          halted = 1'b1;
        end else if (!second_digit) begin
          high_nib = nib;
          second_digit = 1'b1;
          consumed = 1'b1;
        end else begin
          r.out_byte = {high_nib, nib};
          r.byte_valid = 1'b1;
          bytes_out = bytes_out + 1'b1;
          second_digit = 1'b0;
          consumed = 1'b1;
        end
      end
      if (consumed && chars_used != 16'hFFFF) chars_used = chars_used + 1'b1;
      if (last) begin
        r.done = 1'b1;
        if (room_err) r.status = ST_ROOM;
        else if (second_digit || (halted && !regs.stop_allowed)) r.status = ST_MALFORMED;
        else r.status = ST_OK;
        r.byte_count = (r.status == ST_OK) ? bytes_out : 16'd0;
        // dangling high digit is not counted
        r.end_pos = chars_used - second_digit;
        clear_text();
      end
      if (last || r.byte_valid) due_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(logic [OUT_DATA_BITS-1:0] data, logic byte_valid, logic done);
      result_t want;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: result word expected none actual tdata %h tuser %b tlast %b",
                 $time, data, byte_valid, done);
        return;
      end
      want = due_words.pop_front();
      compare_field("out_byte", want.out_byte, data[7:0]);
      compare_field("byte_valid", want.byte_valid, byte_valid);
      compare_field("done", want.done, done);
      compare_field("status", want.status, data[9:8]);
      compare_field("byte_count", want.byte_count, data[25:10]);
      compare_field("end_position", want.end_pos, data[41:26]);
      compare_field("padding", 16'd0, data[OUT_DATA_BITS-1:42]);
    endfunction

    function int pending();
      return due_words.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata;
  logic                     s_axis_tuser;
  logic                     s_axis_tlast;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  byte_scoreboard sb = new();
  text_word_t     text_words[$];
  int             items_sent;
  int             burst_left;
  bit             rx_hold_req;
  int unsigned    cycle_count = 0;

  hex_text_to_bytes u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : result_sink
    rx_mode_t mode;
    int       mode_left;
    int       tick;
    m_axis_tready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      tick++;
      case (mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= tick[1];
      endcase
    end
  end

  function automatic void push_char(logic [7:0] c);
    text_words.push_back('{ch: c, no_char: 1'b0});
  endfunction

  function automatic void push_empty();
    text_words.push_back('{ch: 8'($urandom), no_char: 1'b1});
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  function automatic logic [7:0] hex_char();
    logic [7:0] up;
    int         v;
    v = $urandom_range(0, 15);
    if (v < 10) return CHAR_ZERO + 8'(v);
    up = CHAR_ALPHA + 8'(v);
    return $urandom_range(0, 1) ? (up | ~CASE_MASK) : up;
  endfunction

  function automatic logic [7:0] active_sep();
    case ($urandom_range(0, 2))
      0:       return CHAR_NUL;
      1:       return sb.regs.ignore_char_a;
      default: return sb.regs.ignore_char_b;
    endcase
  endfunction

  function automatic logic [7:0] any_sep_char();
    case ($urandom_range(0, 5))
      0:       return ":";
      1:       return " ";
      2:       return "-";
      3:       return ",";
      4:       return CHAR_NUL;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(addr, data);
  endtask

  task automatic configure(logic [15:0] mb, logic [15:0] ic, logic [15:0] ca,
                           logic [15:0] cb, logic [15:0] sa);
    write_reg(CFG_MAX_BYTES, mb);
    write_reg(CFG_IGNORE_COUNT, ic);
    write_reg(CFG_IGNORE_CHAR_A, ca);
    write_reg(CFG_IGNORE_CHAR_B, cb);
    write_reg(CFG_STOP_ALLOWED, sa);
    // unmapped indexes should be ignored
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_STOP_ALLOWED + CFG_ADDR_BITS'($urandom_range(1, 3)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic configure_random(int phase_no);
    logic [15:0] mb;
    case (phase_no % 4)
      0:       mb = 16'd0;
      1:       mb = 16'hFFFF;
      2:       mb = 16'($urandom_range(1, 8));
      default: mb = 16'($urandom);
    endcase
    configure(mb, {14'($urandom), 2'(phase_no + 1)}, {8'($urandom), any_sep_char()},
              {8'($urandom), any_sep_char()}, 16'($urandom));
  endtask

  task automatic send_text(bit steady);
    int   i;
    logic last;
    for (i = 0; i < text_words.size(); i++) begin
      last = (i == text_words.size() - 1);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= text_words[i].ch;
      s_axis_tuser  <= text_words[i].no_char;
      s_axis_tlast  <= last;
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      sb.note_word(text_words[i].ch, text_words[i].no_char, last);
      if (!text_words[i].no_char || last) items_sent++;
      if (!steady) begin
        if (burst_left == 0) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
          burst_left = $urandom_range(1, 16);
        end else begin
          burst_left--;
        end
      end
    end
    text_words.delete();
  endtask

  task automatic build_random_text();
    text_kind_t kind;
    int         pairs;
    int         broken_at;
    int         pick;
    int         i;
    pick = $urandom_range(0, 9);
    if (pick <= 5) kind = TXT_CLEAN;
    else if (pick == 6) kind = TXT_ODD;
    else if (pick <= 8) kind = TXT_BROKEN;
    else kind = TXT_NOISE;
    pairs = $urandom_range(0, 10);
    broken_at = $urandom_range(0, pairs);
    if (kind == TXT_NOISE) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 5) == 0) push_empty();
        else push_char(8'($urandom));
      end
    end else begin
      for (i = 0; i < pairs; i++) begin
        if (sb.regs.ignore_count != 0)
          repeat ($urandom_range(0, 2)) push_char(active_sep());
        if ($urandom_range(0, 7) == 0) push_empty();
        push_char(hex_char());
        // separator or junk between the two digits of a pair
        if (kind == TXT_BROKEN && i == broken_at)
          push_char($urandom_range(0, 1) ? active_sep() : 8'($urandom));
        push_char(hex_char());
      end
      if (kind == TXT_ODD) push_char(hex_char());
      if (kind == TXT_BROKEN) begin
        if (broken_at == pairs) push_char(8'($urandom));
        repeat ($urandom_range(0, 4)) push_char($urandom_range(0, 1) ? hex_char() : 8'($urandom));
      end
    end
    if ($urandom_range(0, 1) || text_words.size() == 0) push_empty();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase_no;
    int phase_end;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    rx_hold_req = 1'b0;
    items_sent = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed texts
    configure(16'hFFFF, 16'd2, ":", " ", 16'd0);
    push_empty();
    send_text(1'b0);
    push_str("09: aF ");
    push_char(CHAR_NUL);
    push_str("fA");
    send_text(1'b0);
    push_empty();
    push_str("F:x");
    push_empty();
    send_text(1'b0);
    push_str("1");
    push_empty();
    send_text(1'b0);
    push_str("12g");
    send_text(1'b0);
    drain();
    configure(16'd1, 16'd2, ":", " ", 16'd1);
    push_str("345");
    send_text(1'b0);
    push_str("77");
    push_char(8'hFF);
    push_str("0");
    send_text(1'b0);
    drain();

    // random texts under changing settings
    items_sent = 0;
    phase_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      configure_random(phase_no);
      if (phase_no == PRESSURE_PHASE) rx_hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        build_random_text();
        send_text(phase_no == PRESSURE_PHASE || phase_no % 4 == 3);
      end
      drain();
      phase_no++;
    end

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/htb_pkg.sv
design/htb_classify.sv
design/hex_text_to_bytes.sv
dv/testbench.sv
